// File: rtl/core/dfatr_pkg.sv
// dfatr_pkg: shared types, field widths, opcodes and constants of the dfa token recognizer
// no dependencies; imported by the interfaces, the output queue and the top level

package dfatr_pkg;

  localparam int OPC_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int STATE_W = 6;
  localparam int TYPE_W  = 9;

  // default table geometry
  localparam int STATE_COUNT_DEF = 64;
  localparam int CHAR_COUNT_DEF  = 256;

  // number of legal token types, 0 .. TYPE_COUNT-1
  localparam int TYPE_COUNT = 256;

  // output queue depth, must be a power of two
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef logic [OPC_W-1:0]          opcode_t;
  typedef logic [CHAR_W-1:0]         char_t;
  typedef logic [STATE_W-1:0]        state_t;
  typedef logic signed [TYPE_W-1:0]  type_t;

  localparam opcode_t OP_STEP        = 2'd0;
  localparam opcode_t OP_RESTART     = 2'd1;
  localparam opcode_t OP_WRITE_TRANS = 2'd2;
  localparam opcode_t OP_WRITE_TYPE  = 2'd3;

  localparam state_t DEAD_STATE  = 6'd0;
  localparam state_t START_STATE = 6'd1;
  localparam type_t  NO_TYPE     = -9'sd1;

  typedef struct packed {
    state_t current_state;
    type_t  token_type;
    logic   dead_end;
    logic   status;
  } rsp_t;

endpackage

// File: rtl/core/dfatr_if.sv
// dfatr_if: valid/ready channel interfaces for command and result transactions
// depends on dfatr_pkg

interface dfatr_cmd_if import dfatr_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  char_t   char_code;
  state_t  state_index;
  state_t  target_state;
  type_t   type_value;

  modport source(output valid, output opcode, output char_code, output state_index,
                 output target_state, output type_value, input ready);
  modport sink(input valid, input opcode, input char_code, input state_index,
               input target_state, input type_value, output ready);
endinterface

interface dfatr_rsp_if import dfatr_pkg::*; ();
  logic   valid;
  logic   ready;
  state_t current_state;
  type_t  token_type;
  logic   dead_end;
  logic   status;

  modport source(output valid, output current_state, output token_type, output dead_end,
                 output status, input ready);
  modport sink(input valid, input current_state, input token_type, input dead_end,
               input status, output ready);
endinterface

// File: rtl/core/dfatr_out_fifo.sv
// dfatr_out_fifo: small result queue between the pipeline and the result channel
// depends on dfatr_pkg

module dfatr_out_fifo import dfatr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rsp_t              push_data,
  input  logic              pop,
  output rsp_t              head,
  output logic [OUT_CW-1:0] count
);

  rsp_t              entries [OUT_DEPTH];
  logic [OUT_PW-1:0] wr_ptr;
  logic [OUT_PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PW'(1);
      end
      count <= count + OUT_CW'(push) - OUT_CW'(pop);
    end
  end

  assign head = entries[rd_ptr];

endmodule

// File: rtl/core/dfa_token_recognizer.sv
// dfa_token_recognizer: table-driven dfa token recognizer, top level
// result path: a command passes the stage 1 registers, the stage 2 registers and the
//   output queue before its result is offered on the result channel
// throughput: one command transaction per cycle while the output queue has room and no
//   clearing pass runs, also step after step: table read data feeds the next address directly
// reset: synchronous; state goes to the start state with no token type, then a clearing
//   pass zeroes all STATE_COUNT*CHAR_COUNT transition table entries (16384 by default)
// depends on dfatr_pkg, dfatr_if and dfatr_out_fifo

module dfa_token_recognizer import dfatr_pkg::*; #(
  parameter int STATE_COUNT = STATE_COUNT_DEF,
  parameter int CHAR_COUNT  = CHAR_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dfatr_cmd_if.sink   cmd,
  dfatr_rsp_if.source rsp
);

  // transition table geometry, entry index is state * CHAR_COUNT + char
  localparam int DEPTH = STATE_COUNT * CHAR_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(STATE_COUNT);

  localparam logic [12:0]     STATE_LIM = 13'(STATE_COUNT);
  localparam logic [CHAR_W:0] CHAR_LIM  = (CHAR_W + 1)'(CHAR_COUNT);
  localparam logic [AW-1:0]   LAST_IDX  = AW'(DEPTH - 1);

  // ---------------------------------------------------------------------------
  // architectural state
  // ---------------------------------------------------------------------------
  state_t dfa_state;
  state_t dfa_state_next;
  type_t  last_type;
  type_t  last_type_next;

  // clearing pass over the transition table after reset
  logic          clr_busy;
  logic [AW-1:0] clr_idx;

  // output queue
  rsp_t              rsp_data;
  rsp_t              head;
  logic [OUT_CW-1:0] out_count;
  logic              pop;

  // ---------------------------------------------------------------------------
  // stage 0: accept, transition table read address
  // ---------------------------------------------------------------------------
  logic          v1;
  logic          v2;
  logic          cmd_fire;
  state_t        rd_state0;
  logic          ch_ok0;
  logic [AW-1:0] addr0;

  // the queue has room for everything already in flight plus this transaction
  assign cmd.ready = !clr_busy &&
                     (({1'b0, out_count} + (OUT_CW + 1)'(v1) + (OUT_CW + 1)'(v2))
                      < (OUT_CW + 1)'(OUT_DEPTH));
  assign cmd_fire  = cmd.valid && cmd.ready;

  // a step reads from the state left by the item ahead, which is resolved in stage 1
  assign rd_state0 = (cmd.opcode == OP_STEP) ? dfa_state_next : cmd.state_index;
  assign ch_ok0    = {1'b0, cmd.char_code} < CHAR_LIM;
  assign addr0     = AW'(rd_state0) * AW'(CHAR_COUNT) + AW'(cmd.char_code);

  // stage 1 registers
  opcode_t       op1;
  logic          ch_ok1;
  state_t        sidx1;
  state_t        nst1;
  type_t         tval1;
  logic [AW-1:0] addr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op1    <= cmd.opcode;
      ch_ok1 <= ch_ok0;
      sidx1  <= cmd.state_index;
      nst1   <= cmd.target_state;
      tval1  <= cmd.type_value;
      addr1  <= addr0;
    end
  end

  // ---------------------------------------------------------------------------
  // transition table, one write port shared with the clearing pass
  // ---------------------------------------------------------------------------
  state_t        trans_mem [DEPTH];
  state_t        trans_rd;
  logic          trans_we;
  logic          tw_we;
  logic [AW-1:0] tw_addr;
  state_t        tw_data;

  assign tw_we   = clr_busy || trans_we;
  assign tw_addr = clr_busy ? clr_idx : addr1;
  assign tw_data = clr_busy ? DEAD_STATE : nst1;

  always_ff @(posedge clk) begin
    if (tw_we) begin
      trans_mem[tw_addr] <= tw_data;
    end
    if (cmd_fire) begin
      trans_rd <= trans_mem[addr0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == LAST_IDX) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // last table write, for the read that shared its edge
  logic          wl_v;
  logic [AW-1:0] wl_addr;
  state_t        wl_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wl_v <= 1'b0;
    end else begin
      wl_v <= trans_we;
    end
  end

  always_ff @(posedge clk) begin
    wl_addr <= addr1;
    wl_data <= nst1;
  end

  // ---------------------------------------------------------------------------
  // stage 1: next state, transition write check
  // ---------------------------------------------------------------------------
  state_t        old1;
  state_t        next1;
  logic          sidx_ok1;
  logic          nst_ok1;
  logic          t_rej;
  logic [SW-1:0] ta1;

  assign old1     = (wl_v && (wl_addr == addr1)) ? wl_data : trans_rd;
  assign next1    = ch_ok1 ? old1 : DEAD_STATE;
  assign sidx_ok1 = {7'b0, sidx1} < STATE_LIM;
  assign nst_ok1  = {7'b0, nst1} < STATE_LIM;

  // dead source, start target, out of range, or a different target already stored
  assign t_rej = !sidx_ok1 || !nst_ok1 || !ch_ok1 ||
                 (sidx1 == DEAD_STATE) || (nst1 == START_STATE) ||
                 ((old1 != DEAD_STATE) && (old1 != nst1));

  assign trans_we = v1 && (op1 == OP_WRITE_TRANS) && !t_rej && (old1 == DEAD_STATE);

  always_comb begin
    dfa_state_next = dfa_state;
    if (v1) begin
      case (op1)
        OP_STEP:    dfa_state_next = next1;
        OP_RESTART: dfa_state_next = START_STATE;
        default:    dfa_state_next = dfa_state;
      endcase
    end
  end

  // type table read: the new state's type for a step, the command's state index otherwise
  assign ta1 = (op1 == OP_STEP) ? SW'(next1) : SW'(sidx1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state <= START_STATE;
    end else begin
      dfa_state <= dfa_state_next;
    end
  end

  // stage 2 registers
  opcode_t       op2;
  logic          sidx_ok2;
  type_t         tval2;
  logic [SW-1:0] ta2;
  state_t        state2;
  logic          t_rej2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      op2      <= op1;
      sidx_ok2 <= sidx_ok1;
      tval2    <= tval1;
      ta2      <= ta1;
      state2   <= dfa_state_next;
      t_rej2   <= t_rej;
    end
  end

  // ---------------------------------------------------------------------------
  // type table: data in memory, a valid bit per state marks entries ever written
  // ---------------------------------------------------------------------------
  type_t            type_mem [STATE_COUNT];
  logic [STATE_COUNT-1:0] type_vld;
  type_t            type_rd;
  logic             y_we;

  always_ff @(posedge clk) begin
    if (y_we) begin
      type_mem[ta2] <= tval2;
    end
    if (v1) begin
      type_rd <= type_mem[ta1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_vld <= '0;
    end else if (y_we) begin
      type_vld[ta2] <= 1'b1;
    end
  end

  logic          yl_v;
  logic [SW-1:0] yl_addr;
  type_t         yl_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      yl_v <= 1'b0;
    end else begin
      yl_v <= y_we;
    end
  end

  always_ff @(posedge clk) begin
    yl_addr <= ta2;
    yl_data <= tval2;
  end

  // ---------------------------------------------------------------------------
  // stage 2: token type, type write check, result
  // ---------------------------------------------------------------------------
  type_t told;
  logic  y_rej;
  logic  status2;

  always_comb begin
    if (!type_vld[ta2]) begin
      told = NO_TYPE;
    end else if (yl_v && (yl_addr == ta2)) begin
      told = yl_data;
    end else begin
      told = type_rd;
    end
  end

  // out of range state or type, or a different type already set
  assign y_rej = !sidx_ok2 || (tval2 < NO_TYPE) || (int'(tval2) >= TYPE_COUNT) ||
                 ((told != tval2) && (told != NO_TYPE));

  assign y_we = v2 && (op2 == OP_WRITE_TYPE) && !y_rej && (told != tval2);

  always_comb begin
    last_type_next = last_type;
    status2        = 1'b0;
    if (v2) begin
      case (op2)
        OP_STEP: begin
          if (told != NO_TYPE) begin
            last_type_next = told;
          end
        end
        OP_RESTART:     last_type_next = NO_TYPE;
        OP_WRITE_TRANS: status2 = t_rej2;
        OP_WRITE_TYPE:  status2 = y_rej;
        default:        status2 = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_type <= NO_TYPE;
    end else begin
      last_type <= last_type_next;
    end
  end

  assign rsp_data.current_state = state2;
  assign rsp_data.token_type    = last_type_next;
  assign rsp_data.dead_end      = (state2 == DEAD_STATE);
  assign rsp_data.status        = status2;

  // ---------------------------------------------------------------------------
  // result queue and channel
  // ---------------------------------------------------------------------------
  assign pop = rsp.valid && rsp.ready;

  dfatr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (v2),
    .push_data (rsp_data),
    .pop       (pop),
    .head      (head),
    .count     (out_count)
  );

  assign rsp.valid         = (out_count != '0);
  assign rsp.current_state = head.current_state;
  assign rsp.token_type    = head.token_type;
  assign rsp.dead_end      = head.dead_end;
  assign rsp.status        = head.status;

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for dfa_token_recognizer, directed table then random lexing runs
// depends on dfatr_pkg, dfatr_if and the dfa_token_recognizer rtl; one result per command
`timescale 1ns / 100ps

module tb_top;
  import dfatr_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RST_CYCLES  = 10;
  localparam int DRAIN_WAIT  = 20;      // settling time after the last owed result is taken
  localparam int LONG_HOLD   = 400;     // receiver back-pressure stretch
  localparam int ALPHA_N     = 8;
  localparam int NUM_DIR     = 25;

  typedef struct packed {
    opcode_t opcode;
    char_t   char_code;
    state_t  state_index;
    state_t  target_state;
    type_t   type_value;
  } cmd_t;

  // one row of the directed table; expectation used only where typed is set
  typedef struct packed {
    opcode_t opcode;
    char_t   char_code;
    state_t  state_index;
    state_t  target_state;
    type_t   type_value;
    logic    typed;
    state_t  e_state;
    type_t   e_type;
    logic    e_dead;
    logic    e_status;
  } lex_row_t;

  logic clk = 1'b0;
  logic rst;

  dfatr_cmd_if cmd_bus ();
  dfatr_rsp_if rsp_bus ();

  dfa_token_recognizer u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // lexer shadow: tables, current state and the last token type seen
  // ---------------------------------------------------------------------------
  state_t trans_tbl [STATE_COUNT_DEF][CHAR_COUNT_DEF];
  type_t  type_tbl  [STATE_COUNT_DEF];
  state_t lex_state;
  type_t  lex_type;

  rsp_t   token_rsp_q [$];   // results still owed by the block
  char_t  alphabet [ALPHA_N];

  int send_idle_pct;
  int rcv_idle_pct;
  int stall_reqs;            // bumped by the stimulus to ask for a long hold-off
  int stall_done;
  int fail_cnt;
  int n_cmds;
  int n_steps;
  int n_dead;
  int n_rejects;
  int n_checked;

  // moves the shadow machine by one command and returns the result it owes
  function automatic rsp_t lex_predict(input cmd_t c);
    rsp_t   r;
    state_t nxt;
    logic   rej;
    int     tv;
    rej = 1'b0;
    case (c.opcode)
      OP_STEP: begin
        nxt = trans_tbl[lex_state][c.char_code];
        lex_state = nxt;
        if (type_tbl[nxt] != NO_TYPE) lex_type = type_tbl[nxt];
        n_steps++;
        if (nxt == DEAD_STATE) n_dead++;
      end
      OP_RESTART: begin
        lex_state = START_STATE;
        lex_type  = NO_TYPE;
      end
      OP_WRITE_TRANS: begin
        // no edges out of the dead state, none back into the start state
        if (c.state_index == DEAD_STATE || c.target_state == START_STATE) begin
          rej = 1'b1;
        end else if (trans_tbl[c.state_index][c.char_code] == DEAD_STATE) begin
          trans_tbl[c.state_index][c.char_code] = c.target_state;
        end else begin
          rej = (trans_tbl[c.state_index][c.char_code] != c.target_state);
        end
      end
      default: begin
        tv = c.type_value;
        if (tv < -1 || tv >= TYPE_COUNT) begin
          rej = 1'b1;
        end else if (c.type_value != type_tbl[c.state_index]) begin
          if (type_tbl[c.state_index] != NO_TYPE) rej = 1'b1;
          else type_tbl[c.state_index] = c.type_value;
        end
      end
    endcase
    if (rej) n_rejects++;
    r.current_state = lex_state;
    r.token_type    = lex_type;
    r.dead_end      = (lex_state == DEAD_STATE);
    r.status        = rej;
    return r;
  endfunction

  // random command shaped like a lexer's life: build a small dfa and walk it
  function automatic cmd_t pick_lexer_cmd();
    cmd_t  c;
    char_t live [$];
    int    sel;
    int    i;
    c.opcode       = OP_STEP;
    c.char_code    = char_t'($urandom);
    c.state_index  = state_t'($urandom);
    c.target_state = state_t'($urandom);
    c.type_value   = type_t'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 5 || (lex_state == DEAD_STATE && sel < 50)) begin
      c.opcode = OP_RESTART;
    end else if (sel < 50) begin
      c.opcode = OP_STEP;
      for (i = 0; i < ALPHA_N; i++)
        if (trans_tbl[lex_state][alphabet[i]] != DEAD_STATE) live = {live, alphabet[i]};
      sel = $urandom_range(0, 99);
      if (sel < 75 && live.size() != 0)
        c.char_code = live[$urandom_range(0, live.size() - 1)];
      else if (sel < 90)
        c.char_code = alphabet[$urandom_range(0, ALPHA_N - 1)];
    end else if (sel < 80) begin
      c.opcode = OP_WRITE_TRANS;
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        c.state_index  = state_t'($urandom_range(1, 13));
        c.target_state = state_t'($urandom_range(2, 13));
        c.char_code    = alphabet[$urandom_range(0, ALPHA_N - 1)];
      end else if (sel < 90) begin
        c.target_state = DEAD_STATE;
      end else if (sel < 95) begin
        c.target_state = START_STATE;
      end else begin
        c.state_index = DEAD_STATE;
      end
    end else begin
      c.opcode = OP_WRITE_TYPE;
      if ($urandom_range(0, 99) < 85) c.state_index = state_t'($urandom_range(0, 13));
      sel = $urandom_range(0, 99);
      if (sel < 70) c.type_value = type_t'($urandom_range(0, 255));
      else if (sel < 80) c.type_value = NO_TYPE;
    end
    return c;
  endfunction

  // offers one command, books its expected result once ready is seen high at a falling edge
  task automatic send_cmd(input cmd_t c, input logic use_typed, input rsp_t typed_rsp);
    rsp_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.opcode       <= c.opcode;
    cmd_bus.char_code    <= c.char_code;
    cmd_bus.state_index  <= c.state_index;
    cmd_bus.target_state <= c.target_state;
    cmd_bus.type_value   <= c.type_value;
    // ready only moves at rising edges, so the falling edge shows what the next edge takes
    @(negedge clk);
    while (cmd_bus.ready !== 1'b1) @(negedge clk);
    pred = lex_predict(c);
    token_rsp_q = {token_rsp_q, (use_typed ? typed_rsp : pred)};
    n_cmds++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // directed table: corner cases of the write rules and of stepping
  // ---------------------------------------------------------------------------
  lex_row_t lex_rows [NUM_DIR] = '{
    // step with the top character before anything is loaded falls into the dead state
    '{OP_STEP,        8'hFF, 6'h3F, 6'h3F, 9'h0FF, 1'b1, DEAD_STATE,  NO_TYPE, 1'b1, 1'b0},
    '{OP_RESTART,     8'h00, 6'h00, 6'h00, 9'h100, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    // edge out of the dead state, edge into the start state
    '{OP_WRITE_TRANS, 8'h41, 6'h00, 6'h02, 9'h000, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b1},
    '{OP_WRITE_TRANS, 8'h41, 6'h01, 6'h01, 9'h000, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b1},
    // types below -1, down to the most negative code
    '{OP_WRITE_TYPE,  8'h00, 6'h02, 6'h00, 9'h1FE, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b1},
    '{OP_WRITE_TYPE,  8'h00, 6'h02, 6'h00, 9'h100, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b1},
    // top type on top state, same again, then a conflicting one and a clear attempt
    '{OP_WRITE_TYPE,  8'h00, 6'h3F, 6'h00, 9'h0FF, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    '{OP_WRITE_TYPE,  8'h00, 6'h3F, 6'h00, 9'h0FF, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    '{OP_WRITE_TYPE,  8'h00, 6'h3F, 6'h00, 9'h007, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b1},
    '{OP_WRITE_TYPE,  8'h00, 6'h3F, 6'h00, NO_TYPE, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b1},
    // -1 onto an untyped state matches what is stored
    '{OP_WRITE_TYPE,  8'h00, 6'h05, 6'h00, NO_TYPE, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    // edge 1 -FF-> 63, the same edge again, then a conflicting target
    '{OP_WRITE_TRANS, 8'hFF, 6'h01, 6'h3F, 9'h000, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    '{OP_WRITE_TRANS, 8'hFF, 6'h01, 6'h3F, 9'h000, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    '{OP_WRITE_TRANS, 8'hFF, 6'h01, 6'h02, 9'h000, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b1},
    // zero target onto an empty entry is taken and leaves it empty
    '{OP_WRITE_TRANS, 8'h00, 6'h3F, 6'h00, 9'h000, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    // walk: into 63 picks up type 255, then dead, and dead stays dead
    '{OP_STEP,        8'hFF, 6'h00, 6'h00, 9'h000, 1'b1, 6'h3F,       9'h0FF,  1'b0, 1'b0},
    '{OP_STEP,        8'h00, 6'h00, 6'h00, 9'h000, 1'b1, DEAD_STATE,  9'h0FF,  1'b1, 1'b0},
    '{OP_STEP,        8'h00, 6'h00, 6'h00, 9'h000, 1'b1, DEAD_STATE,  9'h0FF,  1'b1, 1'b0},
    // the dead state itself may carry a type
    '{OP_WRITE_TYPE,  8'h00, 6'h00, 6'h00, 9'h000, 1'b1, DEAD_STATE,  9'h0FF,  1'b1, 1'b0},
    '{OP_STEP,        8'h03, 6'h00, 6'h00, 9'h000, 1'b1, DEAD_STATE,  9'h000,  1'b1, 1'b0},
    '{OP_RESTART,     8'h00, 6'h00, 6'h00, 9'h000, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    '{OP_WRITE_TYPE,  8'h00, 6'h01, 6'h00, 9'h009, 1'b1, START_STATE, NO_TYPE, 1'b0, 1'b0},
    // a short path built and walked, checked by the shadow
    '{OP_WRITE_TRANS, 8'h80, 6'h01, 6'h28, 9'h000, 1'b0, DEAD_STATE,  9'h000,  1'b0, 1'b0},
    '{OP_WRITE_TYPE,  8'h00, 6'h28, 6'h00, 9'h080, 1'b0, DEAD_STATE,  9'h000,  1'b0, 1'b0},
    '{OP_STEP,        8'h80, 6'h00, 6'h00, 9'h000, 1'b0, DEAD_STATE,  9'h000,  1'b0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    cmd_t c;
    rsp_t typed_rsp;
    int   phase;
    int   n_rand;
    int   i;
    int   k;

    rst                  <= 1'b1;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.opcode       <= OP_STEP;
    cmd_bus.char_code    <= '0;
    cmd_bus.state_index  <= '0;
    cmd_bus.target_state <= '0;
    cmd_bus.type_value   <= '0;
    stall_reqs = 0;
    n_cmds = 0;
    n_steps = 0;
    n_dead = 0;
    n_rejects = 0;
    send_idle_pct = 37;
    rcv_idle_pct  = 71;

    // shadow reset: empty tables, start state, no type
    for (i = 0; i < STATE_COUNT_DEF; i++) begin
      type_tbl[i] = NO_TYPE;
      for (k = 0; k < CHAR_COUNT_DEF; k++) trans_tbl[i][k] = DEAD_STATE;
    end
    lex_state = START_STATE;
    lex_type  = NO_TYPE;

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // the block clears its table after reset and holds ready low meanwhile
    for (i = 0; i < NUM_DIR; i++) begin
      c.opcode       = lex_rows[i].opcode;
      c.char_code    = lex_rows[i].char_code;
      c.state_index  = lex_rows[i].state_index;
      c.target_state = lex_rows[i].target_state;
      c.type_value   = lex_rows[i].type_value;
      typed_rsp.current_state = lex_rows[i].e_state;
      typed_rsp.token_type    = lex_rows[i].e_type;
      typed_rsp.dead_end      = lex_rows[i].e_dead;
      typed_rsp.status        = lex_rows[i].e_status;
      send_cmd(c, lex_rows[i].typed, typed_rsp);
    end

    // three random phases: slow receiver, slow sender, then full rate
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 37; rcv_idle_pct = 71; n_rand = 600; end
        1: begin send_idle_pct = 71; rcv_idle_pct = 37; n_rand = 640; end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct  = 0;
          n_rand = 640;
          // long receiver hold-off while commands keep coming: output queue fills
          stall_reqs++;
        end
      endcase
      for (i = 0; i < ALPHA_N; i++) alphabet[i] = char_t'($urandom);
      for (i = 0; i < n_rand; i++) begin
        c = pick_lexer_cmd();
        send_cmd(c, 1'b0, typed_rsp);
      end
    end

    cmd_bus.valid <= 1'b0;
    while (token_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("tb_top: %0d transactions, %0d results checked, %0d steps (%0d to dead state)",
             n_cmds, n_checked, n_steps, n_dead);
    $display("tb_top: %0d table writes rejected, long output back-pressure exercised",
             n_rejects);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random ready, plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    stall_done = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_reqs != stall_done) begin
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_done++;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // check each result transaction against the oldest owed result
  initial begin
    fail_cnt  = 0;
    n_checked = 0;
  end

  always @(negedge clk) begin
    rsp_t want;
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (token_rsp_q.size() == 0) begin
        $error("result transaction with nothing expected: state %0d type %0d",
               rsp_bus.current_state, rsp_bus.token_type);
        fail_cnt++;
      end else begin
        want = token_rsp_q.pop_front();
        n_checked++;
        if (rsp_bus.current_state !== want.current_state) begin
          $error("current_state expected %0d got %0d", want.current_state,
                 rsp_bus.current_state);
          fail_cnt++;
        end
        if (rsp_bus.token_type !== want.token_type) begin
          $error("token_type expected %0d got %0d", want.token_type, rsp_bus.token_type);
          fail_cnt++;
        end
        if (rsp_bus.dead_end !== want.dead_end) begin
          $error("dead_end expected %0b got %0b", want.dead_end, rsp_bus.dead_end);
          fail_cnt++;
        end
        if (rsp_bus.status !== want.status) begin
          $error("status expected %0b got %0b", want.status, rsp_bus.status);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: fails the run after a time well beyond the table clear plus the slowest handshakes
  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
